// ===== hdl/sdf_pkg.sv =====
package sdf_pkg;

  // Field widths of the request and result channels.
  localparam int REQ_W     = 2;
  localparam int ELEM_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int COUNT_MAX = 127;

  // Default store depths.
  localparam int EXCLUDE_DEPTH_DEF = 64;
  localparam int RESULT_DEPTH_DEF  = 64;

  // Request codes as they arrive on req_type.
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // Operation decoded by the front end.
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_QUERY,
    OP_NONE
  } op_e;

  // One classified request travelling from front to back.
  typedef struct packed {
    op_e                       op;
    logic signed [ELEM_W-1:0]  element;
  } cmd_t;

endpackage

// ===== hdl/sdf_ram.sv =====
module sdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sdf_front.sv =====
module sdf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sdf_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [sdf_pkg::ELEM_W-1:0]  element_i,
  output logic                               cmd_valid_o,
  output sdf_pkg::cmd_t                      cmd_o,
  input  logic                               cmd_pop_i
);
  import sdf_pkg::*;

  localparam int QueueDepth = 2;
  localparam int QFW        = $clog2(QueueDepth + 1);

  cmd_t           slot_q [QueueDepth];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [QFW-1:0] fill_q, fill_d;
  cmd_t           incoming;
  logic           push, pop;

  // Classify the incoming request into an operation.
  always_comb begin
    incoming.element = element_i;
    case (req_type_i)
      REQ_CLEAR: incoming.op = OP_CLEAR;
      REQ_LOAD:  incoming.op = OP_LOAD;
      REQ_QUERY: incoming.op = OP_QUERY;
      default:   incoming.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (fill_q != QFW'(QueueDepth));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Pointer and fill bookkeeping of the two-entry queue.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    case ({push, pop})
      2'b10:   fill_d = fill_q + QFW'(1);
      2'b01:   fill_d = fill_q - QFW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

// ===== hdl/sdf_back.sv =====
module sdf_back #(
  parameter int EXCLUDE_DEPTH = sdf_pkg::EXCLUDE_DEPTH_DEF,
  parameter int RESULT_DEPTH  = sdf_pkg::RESULT_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  sdf_pkg::cmd_t                      cmd_i,
  output logic                               cmd_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic signed [sdf_pkg::ELEM_W-1:0]  value_o,
  output logic [sdf_pkg::COUNT_W-1:0]        result_count_o,
  output logic                               overflow_o
);
  import sdf_pkg::*;

  localparam int EAW = (EXCLUDE_DEPTH > 1) ? $clog2(EXCLUDE_DEPTH) : 1;
  localparam int RAW = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int ECW = $clog2(EXCLUDE_DEPTH + 1);
  localparam int RCW = $clog2(RESULT_DEPTH + 1);
  localparam int SW  = (ECW > RCW) ? ECW : RCW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   state_q, state_d;
  cmd_t         cmd_q, cmd_d;
  logic [ECW-1:0] ex_cnt_q, ex_cnt_d;
  logic [RCW-1:0] res_fill_q, res_fill_d;
  logic [SW-1:0]  idx_q, idx_d;
  logic [SW-1:0]  len_q, len_d;
  logic         pv_q, pv_d;
  logic         pex_q, pex_d;
  logic         pres_q, pres_d;
  logic         hit_q, hit_d;

  logic                      out_valid_q, out_valid_d;
  logic                      accepted_q, accepted_d;
  logic signed [ELEM_W-1:0]  value_q, value_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic                      overflow_q, overflow_d;
  logic                      out_load;

  logic              rd_en;
  logic              ex_we, res_we;
  logic [ELEM_W-1:0] ex_rdata, res_rdata;
  logic              out_free;

  // Exclusion store: set B elements in load order.
  sdf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (EXCLUDE_DEPTH)
  ) u_exclude_ram (
    .clk_i   (clk_i),
    .we_i    (ex_we),
    .waddr_i (ex_cnt_q[EAW-1:0]),
    .wdata_i (cmd_q.element),
    .re_i    (rd_en),
    .raddr_i (idx_q[EAW-1:0]),
    .rdata_o (ex_rdata)
  );

  // Result store: accepted elements in acceptance order.
  sdf_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RESULT_DEPTH)
  ) u_result_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_fill_q[RAW-1:0]),
    .wdata_i (cmd_q.element),
    .re_i    (rd_en),
    .raddr_i (idx_q[RAW-1:0]),
    .rdata_o (res_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_en    = (state_q == ST_SCAN) && (idx_q < len_q);

  // Sequencer: take a request, sweep both stores for a query, then commit.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    ex_cnt_d   = ex_cnt_q;
    res_fill_d = res_fill_q;
    idx_d      = idx_q;
    len_d      = len_q;
    pv_d       = pv_q;
    pex_d      = pex_q;
    pres_d     = pres_q;
    hit_d      = hit_q;
    cmd_pop_o  = 1'b0;
    ex_we      = 1'b0;
    res_we     = 1'b0;
    out_load   = 1'b0;
    accepted_d = accepted_q;
    overflow_d = overflow_q;
    value_d    = value_q;
    count_d    = count_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          pv_d      = 1'b0;
          hit_d     = 1'b0;
          len_d     = (SW'(ex_cnt_q) > SW'(res_fill_q)) ? SW'(ex_cnt_q) : SW'(res_fill_q);
          state_d   = (cmd_i.op == OP_QUERY) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        // Address goes out this cycle, the data is compared in the next.
        pv_d   = rd_en;
        pex_d  = idx_q < SW'(ex_cnt_q);
        pres_d = idx_q < SW'(res_fill_q);
        if (rd_en) begin
          idx_d = idx_q + SW'(1);
        end
        if (pv_q) begin
          hit_d = hit_q || (pex_q && (ex_rdata == cmd_q.element))
                        || (pres_q && (res_rdata == cmd_q.element));
        end
        if (!rd_en && !pv_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          accepted_d = 1'b0;
          overflow_d = 1'b0;
          value_d    = cmd_q.element;
          case (cmd_q.op)
            OP_CLEAR: begin
              ex_cnt_d   = '0;
              res_fill_d = '0;
            end
            OP_LOAD: begin
              if (ex_cnt_q < ECW'(EXCLUDE_DEPTH)) begin
                ex_we    = 1'b1;
                ex_cnt_d = ex_cnt_q + ECW'(1);
              end else begin
                overflow_d = 1'b1;
              end
            end
            OP_QUERY: begin
              if (!hit_q) begin
                if (res_fill_q < RCW'(RESULT_DEPTH)) begin
                  res_we     = 1'b1;
                  res_fill_d = res_fill_q + RCW'(1);
                  accepted_d = 1'b1;
                end else begin
                  overflow_d = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          // Count reported after this request, saturating at the field maximum.
          count_d = (32'(res_fill_d) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                       : COUNT_W'(res_fill_d);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a finished result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ex_cnt_q    <= '0;
      res_fill_q  <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      pv_q        <= 1'b0;
      pex_q       <= 1'b0;
      pres_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ex_cnt_q    <= ex_cnt_d;
      res_fill_q  <= res_fill_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      pv_q        <= pv_d;
      pex_q       <= pex_d;
      pres_q      <= pres_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    accepted_q <= accepted_d;
    value_q    <= value_d;
    count_q    <= count_d;
    overflow_q <= overflow_d;
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign value_o        = value_q;
  assign result_count_o = count_q;
  assign overflow_o     = overflow_q;

endmodule

// ===== hdl/set_difference_filter_unit.sv =====
// Set difference filter: every request gives exactly one result, in request order. A query
// sweeps both stores up to the size of the larger one; both stores sit in single-read-port
// memories that are swept one address a cycle and compared behind the registered read. A
// two-entry request queue in front and a result register at the output let the request side
// and the result side stall independently.
module set_difference_filter_unit #(
  parameter int EXCLUDE_DEPTH = sdf_pkg::EXCLUDE_DEPTH_DEF,
  parameter int RESULT_DEPTH  = sdf_pkg::RESULT_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sdf_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [sdf_pkg::ELEM_W-1:0]  element_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic signed [sdf_pkg::ELEM_W-1:0]  value_o,
  output logic [sdf_pkg::COUNT_W-1:0]        result_count_o,
  output logic                               overflow_o
);
  import sdf_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front end: classifies requests and queues them.
  sdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .element_i   (element_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: store sweeps, commits and the result register.
  sdf_back #(
    .EXCLUDE_DEPTH (EXCLUDE_DEPTH),
    .RESULT_DEPTH  (RESULT_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .value_o        (value_o),
    .result_count_o (result_count_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== hdl/sdf_checker.sv =====
module sdf_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic                               accepted_i,
  input logic signed [sdf_pkg::ELEM_W-1:0]  value_i,
  input logic [sdf_pkg::COUNT_W-1:0]        result_count_i,
  input logic                               overflow_i
);

  // A stalled result keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i)
      && $stable(accepted_i) && $stable(result_count_i) && $stable(overflow_i))
    else $error("stalled result changed");

  // An element that was accepted was not dropped as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> !overflow_i)
    else $error("result both accepted and overflowed");

  // An accepted element leaves the difference set non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> result_count_i != '0)
    else $error("accepted result with zero count");

  // No result is shown straight out of reset without a request ahead of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) ##1 $past(!rst_ni) |-> !out_valid_i)
    else $error("result shown straight out of reset");

endmodule

bind set_difference_filter_unit sdf_checker u_sdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_i     (accepted_o),
  .value_i        (value_o),
  .result_count_i (result_count_o),
  .overflow_i     (overflow_o)
);
